FILE: src/region_table_translate_check_unit_defines.svh
// Assertion macros for the controller RTL file (rttc_ctrl) of the region table unit.
`ifndef REGION_TABLE_TRANSLATE_CHECK_UNIT_DEFINES_SVH
`define REGION_TABLE_TRANSLATE_CHECK_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define RTTC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RTTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RTTC_ASSERT(label, prop, msg)
`define RTTC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: src/rttc_pkg.sv
`default_nettype none
package rttc_pkg;
    localparam int MAX_REGIONS_DEF = 64;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_COUNT  = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] FAULT_NONE     = 2'd0;
    localparam logic [1:0] FAULT_UNMAPPED = 2'd1;
    localparam logic [1:0] FAULT_PROTECT  = 2'd2;
    localparam logic [1:0] FAULT_BOUNDS   = 2'd3;

    typedef struct packed {
        logic [63:0] start;
        logic [31:0] phys;
        logic [31:0] len;
        logic [2:0]  rights;
    } entry_t;
endpackage
`default_nettype wire

FILE: src/rttc_if.sv
`default_nettype none
interface rttc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [5:0]  entry_slot;
    logic [6:0]  entry_count_in;
    logic [63:0] region_start;
    logic [31:0] region_phys_base;
    logic [31:0] region_length;
    logic [2:0]  region_rights;
    logic [63:0] query_address;
    logic [31:0] access_size;
    logic [2:0]  access_rights;

    modport source (output valid, op, entry_slot, entry_count_in, region_start,
                    region_phys_base, region_length, region_rights, query_address,
                    access_size, access_rights, input ready);
    modport sink (input valid, op, entry_slot, entry_count_in, region_start,
                  region_phys_base, region_length, region_rights, query_address,
                  access_size, access_rights, output ready);
endinterface

interface rttc_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  fault;
    logic [63:0] run_start;
    logic [31:0] run_phys_base;
    logic [31:0] run_length;

    modport source (output valid, fault, run_start, run_phys_base, run_length,
                    input ready);
    modport sink (input valid, fault, run_start, run_phys_base, run_length,
                  output ready);
endinterface
`default_nettype wire

FILE: src/rttc_mem.sv
`default_nettype none
module rttc_mem #(
    parameter int DEPTH = rttc_pkg::MAX_REGIONS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic            clk,
    input  wire logic            we,
    input  wire logic [AW-1:0]   waddr,
    input  wire rttc_pkg::entry_t wdata,
    input  wire logic [AW-1:0]   raddr,
    output rttc_pkg::entry_t     rdata
);
    rttc_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: src/rttc_ctrl.sv
`default_nettype none
`include "region_table_translate_check_unit_defines.svh"
module rttc_ctrl #(
    parameter int MAX_REGIONS = rttc_pkg::MAX_REGIONS_DEF,
    parameter int IW          = $clog2(MAX_REGIONS)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    rttc_req_if.sink              req,
    rttc_rsp_if.source            rsp,
    output logic                  mem_we,
    output logic [IW-1:0]         mem_waddr,
    output rttc_pkg::entry_t      mem_wdata,
    output logic [IW-1:0]         mem_raddr,
    input  wire rttc_pkg::entry_t mem_rdata
);
    localparam int CW  = $clog2(MAX_REGIONS + 1);
    localparam int RLW = 32 + IW + 1;

    typedef enum logic [3:0] {
        IDLE, SRCH_RD, SRCH_CMP, IDX_RD, IDX_CMP, BACK_RD, BACK_CMP,
        FWD_RD, FWD_CMP, CHECK, FINISH
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   lo_reg, lo_next;
    logic [CW-1:0]   hi_reg, hi_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [63:0]     addr_reg, addr_next;
    logic [31:0]     size_reg, size_next;
    logic [2:0]      need_reg, need_next;
    logic [63:0]     rstart_reg, rstart_next;
    logic [31:0]     rphys_reg, rphys_next;
    logic [RLW-1:0]  rlen_reg, rlen_next;
    logic [1:0]      fault_reg, fault_next;
    logic            out_valid_reg, out_valid_next;
    logic [1:0]      out_fault_reg, out_fault_next;
    logic [63:0]     out_start_reg, out_start_next;
    logic [31:0]     out_phys_reg, out_phys_next;
    logic [31:0]     out_len_reg, out_len_next;

    logic [CW:0]     mid_sum;
    logic [CW-1:0]   mid;
    logic [CW-1:0]   idx_m1;
    logic [CW-1:0]   lo_p1;
    logic [CW-1:0]   idx_p1;
    logic [15:0]     slot_wide;
    logic [15:0]     cnt_wide;
    logic            req_fire;
    logic [63:0]     diff;
    logic            rights_ok;
    logic [RLW-1:0]  len_ext;
    logic [64:0]     end_off;

    assign req_fire  = req.valid && req.ready;
    assign req.ready = (state_reg == IDLE);
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg} + (CW + 1)'(1);
    assign mid       = mid_sum[CW:1];
    assign idx_m1    = idx_reg - CW'(1);
    assign lo_p1     = lo_reg + CW'(1);
    assign idx_p1    = idx_reg + CW'(1);
    assign slot_wide = 16'(req.entry_slot);
    assign cnt_wide  = 16'(req.entry_count_in);
    assign rights_ok = ((mem_rdata.rights & need_reg) == need_reg);
    assign len_ext   = RLW'(mem_rdata.len);
    assign end_off   = {1'b0, addr_reg - rstart_reg} + 65'(size_reg);

    assign mem_we    = req_fire && (req.op == rttc_pkg::OP_WRITE)
                       && (slot_wide < 16'(MAX_REGIONS));
    assign mem_waddr = slot_wide[IW-1:0];
    assign mem_wdata = '{start: req.region_start, phys: req.region_phys_base,
                         len: req.region_length, rights: req.region_rights};

    always_comb
    begin
        case (state_reg)
            SRCH_RD: mem_raddr = mid[IW-1:0];
            BACK_RD: mem_raddr = idx_m1[IW-1:0];
            FWD_RD:  mem_raddr = idx_reg[IW-1:0];
            default: mem_raddr = lo_reg[IW-1:0];
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        idx_next       = idx_reg;
        addr_next      = addr_reg;
        size_next      = size_reg;
        need_next      = need_reg;
        rstart_next    = rstart_reg;
        rphys_next     = rphys_reg;
        rlen_next      = rlen_reg;
        fault_next     = fault_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_fault_next = out_fault_reg;
        out_start_next = out_start_reg;
        out_phys_next  = out_phys_reg;
        out_len_next   = out_len_reg;
        diff           = 64'd0;

        case (state_reg)
            IDLE:
            begin
                if (req_fire)
                begin
                    addr_next   = req.query_address;
                    size_next   = req.access_size;
                    need_next   = req.access_rights;
                    rstart_next = 64'd0;
                    rphys_next  = 32'd0;
                    rlen_next   = '0;
                    fault_next  = rttc_pkg::FAULT_NONE;
                    lo_next     = '0;
                    hi_next     = count_reg;
                    state_next  = FINISH;
                    case (req.op)
                        rttc_pkg::OP_COUNT:
                        begin
                            count_next = (cnt_wide > 16'(MAX_REGIONS)) ? CW'(MAX_REGIONS)
                                                                      : cnt_wide[CW-1:0];
                        end
                        rttc_pkg::OP_LOOKUP:
                        begin
                            if (count_reg == '0)
                            begin
                                fault_next = rttc_pkg::FAULT_UNMAPPED;
                            end
                            else if (count_reg > CW'(1))
                            begin
                                state_next = SRCH_RD;
                            end
                            else
                            begin
                                state_next = IDX_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            SRCH_RD:
            begin
                state_next = SRCH_CMP;
            end
            SRCH_CMP:
            begin
                if (addr_reg < mem_rdata.start)
                begin
                    hi_next = mid;
                end
                else
                begin
                    lo_next = mid;
                end
                state_next = ((hi_next - lo_next) > CW'(1)) ? SRCH_RD : IDX_RD;
            end
            IDX_RD:
            begin
                state_next = IDX_CMP;
            end
            IDX_CMP:
            begin
                diff       = addr_reg - mem_rdata.start;
                state_next = FINISH;
                if (addr_reg < mem_rdata.start || diff >= 64'(mem_rdata.len))
                begin
                    fault_next = rttc_pkg::FAULT_UNMAPPED;
                end
                else if (!rights_ok)
                begin
                    fault_next = rttc_pkg::FAULT_PROTECT;
                end
                else
                begin
                    rstart_next = mem_rdata.start;
                    rphys_next  = mem_rdata.phys;
                    rlen_next   = len_ext;
                    if (lo_reg != '0)
                    begin
                        idx_next   = lo_reg;
                        state_next = BACK_RD;
                    end
                    else
                    begin
                        idx_next   = lo_p1;
                        state_next = (lo_p1 < count_reg) ? FWD_RD : CHECK;
                    end
                end
            end
            BACK_RD:
            begin
                state_next = BACK_CMP;
            end
            BACK_CMP:
            begin
                diff = rstart_reg - mem_rdata.start;
                if (rstart_reg >= mem_rdata.start && diff == 64'(mem_rdata.len) && rights_ok)
                begin
                    rstart_next = mem_rdata.start;
                    rphys_next  = mem_rdata.phys;
                    rlen_next   = rlen_reg + len_ext;
                    idx_next    = idx_m1;
                    if (idx_m1 != '0)
                    begin
                        state_next = BACK_RD;
                    end
                    else
                    begin
                        idx_next   = lo_p1;
                        state_next = (lo_p1 < count_reg) ? FWD_RD : CHECK;
                    end
                end
                else
                begin
                    idx_next   = lo_p1;
                    state_next = (lo_p1 < count_reg) ? FWD_RD : CHECK;
                end
            end
            FWD_RD:
            begin
                state_next = FWD_CMP;
            end
            FWD_CMP:
            begin
                diff       = mem_rdata.start - rstart_reg;
                state_next = CHECK;
                if (mem_rdata.start >= rstart_reg && diff == 64'(rlen_reg) && rights_ok)
                begin
                    rlen_next = rlen_reg + len_ext;
                    idx_next  = idx_p1;
                    if (idx_p1 < count_reg)
                    begin
                        state_next = FWD_RD;
                    end
                end
            end
            CHECK:
            begin
                fault_next = (end_off > 65'(rlen_reg)) ? rttc_pkg::FAULT_BOUNDS
                                                       : rttc_pkg::FAULT_NONE;
                state_next = FINISH;
            end
            FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_fault_next = fault_reg;
                    if (fault_reg == rttc_pkg::FAULT_UNMAPPED
                        || fault_reg == rttc_pkg::FAULT_PROTECT)
                    begin
                        out_start_next = 64'd0;
                        out_phys_next  = 32'd0;
                        out_len_next   = 32'd0;
                    end
                    else
                    begin
                        out_start_next = rstart_reg;
                        out_phys_next  = rphys_reg;
                        out_len_next   = (|rlen_reg[RLW-1:32]) ? 32'hFFFF_FFFF
                                                               : rlen_reg[31:0];
                    end
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        idx_reg       <= idx_next;
        addr_reg      <= addr_next;
        size_reg      <= size_next;
        need_reg      <= need_next;
        rstart_reg    <= rstart_next;
        rphys_reg     <= rphys_next;
        rlen_reg      <= rlen_next;
        fault_reg     <= fault_next;
        out_fault_reg <= out_fault_next;
        out_start_reg <= out_start_next;
        out_phys_reg  <= out_phys_next;
        out_len_reg   <= out_len_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.fault         = out_fault_reg;
    assign rsp.run_start     = out_start_reg;
    assign rsp.run_phys_base = out_phys_reg;
    assign rsp.run_length    = out_len_reg;

    `RTTC_ASSERT(a_count_bound, count_reg <= CW'(MAX_REGIONS), "Entry count exceeds the table.")
    `RTTC_ASSERT(a_search_window, (state_reg != SRCH_CMP) || (lo_reg < hi_reg),
                 "Search window is empty.")
    `RTTC_ASSERT(a_fwd_index, (state_reg != FWD_RD) || (idx_reg < count_reg),
                 "Forward walk reads past the valid entries.")
    `RTTC_ASSERT_NEXT(a_leave_idle, req_fire, state_reg != IDLE,
                      "Accepted request did not leave idle.")
endmodule
`default_nettype wire

FILE: src/region_table_translate_check_unit.sv
`default_nettype none
// Region table with address translation and access check. Table writes and count
// updates go from idle straight to the response. A lookup reads the table memory
// one entry at a time through its single read port: it takes the request, runs a
// binary search if more than one entry is valid, reads the matched entry and, if it
// maps the address with the needed rights, walks back and forward over adjoining
// neighbours to merge them and checks the bounds; then it responds. A lookup that
// merges nothing into an inner match examines one neighbour on each side. A new
// request is taken while the previous response still waits in the output register.
module region_table_translate_check_unit #(
    parameter int MAX_REGIONS = rttc_pkg::MAX_REGIONS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rttc_req_if.sink   req,
    rttc_rsp_if.source rsp
);
    localparam int IW = $clog2(MAX_REGIONS);

    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    logic [IW-1:0]    mem_raddr;
    rttc_pkg::entry_t mem_wdata;
    rttc_pkg::entry_t mem_rdata;

    rttc_ctrl #(
        .MAX_REGIONS(MAX_REGIONS),
        .IW(IW)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .rsp(rsp),
        .mem_we(mem_we),
        .mem_waddr(mem_waddr),
        .mem_wdata(mem_wdata),
        .mem_raddr(mem_raddr),
        .mem_rdata(mem_rdata)
    );

    rttc_mem #(
        .DEPTH(MAX_REGIONS),
        .AW(IW)
    ) u_mem (
        .clk(clk),
        .we(mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );
endmodule
`default_nettype wire

FILE: tb/region_table_translate_check_unit_tb.sv
`timescale 1ns / 100ps
module region_table_translate_check_unit_tb;
    localparam int TABLE_DEPTH = rttc_pkg::MAX_REGIONS_DEF;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_ITEMS = 1030;

    typedef struct {
        logic [1:0]  op;
        logic [5:0]  slot;
        logic [6:0]  count;
        logic [63:0] base;
        logic [31:0] phys;
        logic [31:0] len;
        logic [2:0]  rights;
        logic [63:0] addr;
        logic [31:0] size;
        logic [2:0]  need;
    } region_req_t;

    typedef struct {
        logic [1:0]  fault;
        logic [63:0] start;
        logic [31:0] phys;
        logic [31:0] len;
    } translation_t;

    class translation_scoreboard;
        logic [63:0] start_mem [TABLE_DEPTH];
        logic [31:0] phys_mem [TABLE_DEPTH];
        logic [31:0] len_mem [TABLE_DEPTH];
        logic [2:0]  rights_mem [TABLE_DEPTH];
        int unsigned entries;
        translation_t pending [$];
        int errors;

        function new();
            entries = 0;
            errors = 0;
        endfunction

        function bit adjoins(logic [63:0] a, logic [63:0] alen, logic [63:0] b);
            return (b >= a) && ((b - a) == alen);
        endfunction

        function translation_t translate(logic [63:0] addr, logic [31:0] size,
                                         logic [2:0] need);
            translation_t r;
            int unsigned lo, hi, mid, idx, i;
            logic [63:0] rstart, rlen;
            logic [31:0] rphys;
            r = '{default: '0};
            if (entries == 0)
            begin
                r.fault = rttc_pkg::FAULT_UNMAPPED;
                return r;
            end
            lo = 0;
            hi = entries;
            while (hi - lo > 1)
            begin
                mid = (lo + hi + 1) / 2;
                if (addr < start_mem[mid])
                    hi = mid;
                else
                    lo = mid;
            end
            idx = lo;
            if (addr < start_mem[idx] || addr - start_mem[idx] >= {32'd0, len_mem[idx]})
            begin
                r.fault = rttc_pkg::FAULT_UNMAPPED;
                return r;
            end
            if ((rights_mem[idx] & need) != need)
            begin
                r.fault = rttc_pkg::FAULT_PROTECT;
                return r;
            end
            rstart = start_mem[idx];
            rphys = phys_mem[idx];
            rlen = {32'd0, len_mem[idx]};
            for (i = idx; i > 0; i--)
            begin
                if (!adjoins(start_mem[i-1], {32'd0, len_mem[i-1]}, start_mem[i]))
                    break;
                if ((rights_mem[i-1] & need) != need)
                    break;
                rstart = start_mem[i-1];
                rphys = phys_mem[i-1];
                rlen += {32'd0, len_mem[i-1]};
            end
            for (i = idx + 1; i < entries; i++)
            begin
                if (!adjoins(rstart, rlen, start_mem[i]))
                    break;
                if ((rights_mem[i] & need) != need)
                    break;
                rlen += {32'd0, len_mem[i]};
            end
            r.fault = ((addr - rstart) + {32'd0, size} > rlen) ? rttc_pkg::FAULT_BOUNDS
                                                               : rttc_pkg::FAULT_NONE;
            r.start = rstart;
            r.phys = rphys;
            r.len = (rlen > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rlen[31:0];
            return r;
        endfunction

        function void note_request(region_req_t q);
            translation_t r;
            r = '{default: '0};
            if (q.op == rttc_pkg::OP_WRITE)
            begin
                start_mem[q.slot] = q.base;
                phys_mem[q.slot] = q.phys;
                len_mem[q.slot] = q.len;
                rights_mem[q.slot] = q.rights;
            end
            else if (q.op == rttc_pkg::OP_COUNT)
                entries = (q.count > TABLE_DEPTH) ? TABLE_DEPTH : q.count;
            else if (q.op == rttc_pkg::OP_LOOKUP)
                r = translate(q.addr, q.size, q.need);
            pending = {pending, r};
        endfunction

        function void check_response(translation_t got);
            translation_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected response fault %0d", $time, got.fault);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.fault !== want.fault)
            begin
                $display("%0t: fault expected %0d actual %0d", $time, want.fault, got.fault);
                errors++;
            end
            if (got.start !== want.start)
            begin
                $display("%0t: run_start expected %h actual %h", $time, want.start, got.start);
                errors++;
            end
            if (got.phys !== want.phys)
            begin
                $display("%0t: run_phys_base expected %h actual %h", $time, want.phys,
                         got.phys);
                errors++;
            end
            if (got.len !== want.len)
            begin
                $display("%0t: run_length expected %h actual %h", $time, want.len, got.len);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int unsigned cycles;
    bit steady;
    translation_scoreboard sb;

    rttc_req_if req_bus();
    rttc_rsp_if rsp_bus();

    region_table_translate_check_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        translation_t got;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            got.fault = rsp_bus.fault;
            got.start = rsp_bus.run_start;
            got.phys = rsp_bus.run_phys_base;
            got.len = rsp_bus.run_length;
            sb.check_response(got);
        end
    end

    initial
    begin
        int stall;
        rsp_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_bus.valid);
        end
    end

    task automatic send(region_req_t q);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.op <= q.op;
        req_bus.entry_slot <= q.slot;
        req_bus.entry_count_in <= q.count;
        req_bus.region_start <= q.base;
        req_bus.region_phys_base <= q.phys;
        req_bus.region_length <= q.len;
        req_bus.region_rights <= q.rights;
        req_bus.query_address <= q.addr;
        req_bus.access_size <= q.size;
        req_bus.access_rights <= q.need;
        do
            @(posedge clk);
        while (!req_bus.ready);
        sb.note_request(q);
    endtask

    function automatic region_req_t blank_req(logic [1:0] op);
        region_req_t q;
        q = '{default: '0};
        q.op = op;
        return q;
    endfunction

    task automatic write_entry(int slot, logic [63:0] base, logic [31:0] phys,
                               logic [31:0] len, logic [2:0] rights);
        region_req_t q;
        q = blank_req(rttc_pkg::OP_WRITE);
        q.slot = 6'(slot);
        q.base = base;
        q.phys = phys;
        q.len = len;
        q.rights = rights;
        send(q);
    endtask

    task automatic set_count(int n);
        region_req_t q;
        q = blank_req(rttc_pkg::OP_COUNT);
        q.count = 7'(n);
        send(q);
    endtask

    task automatic lookup(logic [63:0] addr, logic [31:0] size, logic [2:0] need);
        region_req_t q;
        q = blank_req(rttc_pkg::OP_LOOKUP);
        q.addr = addr;
        q.size = size;
        q.need = need;
        send(q);
    endtask

    function automatic logic [31:0] pick_length();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return $urandom;
            2: return 32'hFFFF_FFFF;
            default: return $urandom_range(1, 4096);
        endcase
    endfunction

    function automatic logic [31:0] pick_size();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return $urandom;
            2: return 32'hFFFF_FFFF;
            default: return $urandom_range(1, 8192);
        endcase
    endfunction

    task automatic build_and_probe(int n, inout int issued);
        logic [63:0] starts [TABLE_DEPTH];
        logic [31:0] lens [TABLE_DEPTH];
        logic [63:0] cursor;
        logic [63:0] addr;
        logic [2:0]  rights;
        logic [2:0]  need;
        int k, probes;
        cursor = {$urandom, $urandom} >> $urandom_range(0, 40);
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 9) >= 7)
                cursor += $urandom_range(1, 1 << 20);
            starts[k] = cursor;
            lens[k] = pick_length();
            cursor += lens[k];
            rights = ($urandom_range(0, 2) == 0) ? 3'($urandom_range(0, 7)) : 3'd7;
            write_entry(k, starts[k], $urandom, lens[k], rights);
            issued++;
        end
        set_count(n);
        issued++;
        probes = $urandom_range(4, 12);
        for (k = 0; k < probes; k++)
        begin
            int r;
            r = $urandom_range(0, n - 1);
            case ($urandom_range(0, 5))
                0: addr = starts[r];
                1: addr = starts[r] + lens[r] - 1;
                2: addr = starts[r] - 1;
                3: addr = starts[n-1] + lens[n-1];
                default: addr = starts[r] + ((lens[r] == 0) ? 0 : ($urandom % lens[r]));
            endcase
            need = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                               : 3'(3'd1 << $urandom_range(0, 2));
            lookup(addr, pick_size(), need);
            issued++;
        end
    endtask

    task automatic send_noise();
        region_req_t q;
        q.op = 2'($urandom_range(0, 3));
        q.slot = 6'($urandom);
        q.count = 7'($urandom);
        q.base = {$urandom, $urandom};
        q.phys = $urandom;
        q.len = $urandom;
        q.rights = 3'($urandom);
        q.addr = {$urandom, $urandom};
        q.size = $urandom;
        q.need = 3'($urandom);
        send(q);
    endtask

    initial
    begin
        int issued, wait_cycles, n;
        sb = new();
        cycles = 0;
        steady = 1'b0;
        rst_n = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.op = rttc_pkg::OP_WRITE;
        req_bus.entry_slot = '0;
        req_bus.entry_count_in = '0;
        req_bus.region_start = '0;
        req_bus.region_phys_base = '0;
        req_bus.region_length = '0;
        req_bus.region_rights = '0;
        req_bus.query_address = '0;
        req_bus.access_size = '0;
        req_bus.access_rights = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        lookup(64'h0, 32'd1, 3'd1);
        write_entry(0, 64'h0, 32'h1000_0000, 32'h100, 3'd7);
        write_entry(1, 64'h100, 32'h2000_0000, 32'h100, 3'd3);
        write_entry(2, 64'h200, 32'hFFFF_FFFF, 32'h80, 3'd7);
        write_entry(3, 64'hFFFF_FFFF_FFFF_FF00, 32'h0, 32'hFFFF_FFFF, 3'd5);
        set_count(4);
        lookup(64'h150, 32'h10, 3'd1);
        lookup(64'h50, 32'h300, 3'd3);
        lookup(64'h50, 32'h10, 3'd4);
        lookup(64'h150, 32'h10, 3'd4);
        lookup(64'h280, 32'h1, 3'd1);
        lookup(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 3'd1);
        lookup(64'hFFFF_FFFF_FFFF_FF00, 32'h0, 3'd0);
        lookup(64'h0, 32'h0, 3'd7);
        send(blank_req(rttc_pkg::OP_UNUSED));

        issued = 0;
        build_and_probe(TABLE_DEPTH, issued);
        set_count(7'h7F);
        lookup(64'h0, 32'd1, 3'd1);
        set_count(TABLE_DEPTH);
        issued += 3;
        while (issued < RANDOM_ITEMS)
        begin
            steady = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    repeat ($urandom_range(1, 6))
                    begin
                        send_noise();
                        issued++;
                    end
                end
                2: build_and_probe(TABLE_DEPTH, issued);
                default:
                begin
                    n = $urandom_range(1, 8);
                    build_and_probe(n, issued);
                end
            endcase
        end
        steady = 1'b0;
        req_bus.valid <= 1'b0;

        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (300) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+src
src/rttc_pkg.sv
src/rttc_if.sv
src/rttc_mem.sv
src/rttc_ctrl.sv
src/region_table_translate_check_unit.sv
tb/region_table_translate_check_unit_tb.sv
